### design/nsc_pkg.sv
// Shared types, constants and decode functions for the NMEA sentence checker.
// No dependencies; every other design file imports this package.
package nsc_pkg;

	localparam int MAX_LINE_LEN = 128;
	localparam int CNT_W        = $clog2(MAX_LINE_LEN);
	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LINE_LEN - 1);

	localparam int NUM_TYPES = 6;
	localparam logic [2:0] TYPE_NONE = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_BAD_HEX  = 2'd2;
	localparam logic [1:0] ST_NO_STAR  = 2'd3;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam logic [23:0] TYPE_TAB [NUM_TYPES] = '{
		"RMC", "VTG", "GGA", "GSA", "GSV", "GLL"
	};

	typedef struct packed {
		logic             active;
		logic             pending_cr;
		logic [7:0]       xor_acc;
		logic [CNT_W-1:0] char_count;
		logic [2:0]       type_code;
		logic [7:0]       type_hi;
		logic [7:0]       type_lo;
		logic [7:0]       hex_value;
		logic             hex_bad;
		logic             star_seen;
		logic [1:0]       hex_count;
		logic [CNT_W-1:0] star_pos;
	} line_state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] sentence_type;
		logic [1:0] status;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [6:0] line_length;
	} result_t;

	function automatic logic [2:0] type_lookup(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2);
		logic [2:0] code;
		code = TYPE_NONE;
		for (int i = 0; i < NUM_TYPES; i++) begin
			if (TYPE_TAB[i] == {c0, c1, c2}) begin
				code = 3'(i);
			end
		end
		return code;
	endfunction

	// Returns {valid, value}; only 0-9 and uppercase A-F are valid.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = {1'b1, 4'(c - 8'h41 + 8'd10)};
		end else begin
			d = 5'd0;
		end
		return d;
	endfunction

endpackage

### design/nmea_sentence_checker.sv
// NMEA 0183 sentence checker:
//
// Channels: data_byte enters on in_valid/in_ready, one received character per
// word. One result word per complete wanted sentence leaves on
// out_valid/out_ready, carrying sentence_type, status, computed_sum,
// received_sum and line_length. The wanted_types mask is written over the
// APB-style port at address 0 and reads back there.
// The LF that ends a sentence is accepted into an input register that feeds the
// per-line state update, whose result lands in an output register. Throughput
// is one byte per cycle whenever the output is not stalled.
// The input is stalled only while the output register holds a word that the
// receiver has not taken; nothing is dropped.
// Reset clears both registers, leaves the checker waiting for a dollar sign,
// and sets wanted_types to all six types.
// Depends on nsc_pkg, nsc_apb_regs and nsc_line_fsm.
module nmea_sentence_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  sentence_type,
	output logic [1:0]  status,
	output logic [7:0]  computed_sum,
	output logic [7:0]  received_sum,
	output logic [6:0]  line_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nsc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	logic [5:0] wanted;
	result_t    res;
	result_t    out_q;

	assign advance = !out_q.valid || out_ready;
	assign step = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	nsc_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.wanted_types (wanted)
	);

	nsc_line_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (byte_s1),
		.wanted_types (wanted),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1 <= 8'd0;
			out_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
				byte_s1 <= data_byte;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_q <= step ? res : '0;
			end
		end
	end

	assign out_valid = out_q.valid;
	assign sentence_type = out_q.sentence_type;
	assign status = out_q.status;
	assign computed_sum = out_q.computed_sum;
	assign received_sum = out_q.received_sum;
	assign line_length = out_q.line_length;

endmodule

### design/nsc_apb_regs.sv
// APB-style register file holding the wanted_types mask.
// Depends on nsc_pkg for the number of sentence types.
module nsc_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [5:0]  wanted_types
);
	import nsc_pkg::*;

	logic [NUM_TYPES-1:0] wanted_q;

	assign pready = 1'b1;
	assign wanted_types = wanted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= '1;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			wanted_q <= pwdata[NUM_TYPES-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (!paddr[2]) begin
			prdata = {26'd0, wanted_q};
		end
	end

endmodule

### design/nsc_line_fsm.sv
// Per-sentence state: type match, running XOR, hex checksum decode and length.
// Depends on nsc_pkg for the state and result structs and decode functions.
module nsc_line_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic [5:0]         wanted_types,
	output nsc_pkg::result_t   res
);
	import nsc_pkg::*;

	localparam line_state_t LINE_IDLE = '{type_code: TYPE_NONE, default: '0};

	line_state_t st_q;
	line_state_t st_d;
	line_state_t st_tmp;
	logic [CNT_W-1:0] len_full;
	logic [10:0]      len_ext;

	function automatic line_state_t take_char(input line_state_t s, input logic [7:0] c);
		line_state_t n;
		logic        in_window;
		logic [4:0]  d;
		n = s;
		in_window = s.char_count < LIMIT;
		d = hex_digit(c);
		if (!s.star_seen) begin
			if (in_window) begin
				if (c == CH_STAR) begin
					n.star_seen = 1'b1;
					n.star_pos = s.char_count;
				end else begin
					n.xor_acc = s.xor_acc ^ c;
					if (s.char_count == CNT_W'(2)) begin
						n.type_hi = c;
					end else if (s.char_count == CNT_W'(3)) begin
						n.type_lo = c;
					end else if (s.char_count == CNT_W'(4)) begin
						n.type_code = type_lookup(s.type_hi, s.type_lo, c);
					end
				end
			end
		end else if (s.hex_count < 2'd2) begin
			if (!in_window || !d[4]) begin
				n.hex_bad = 1'b1;
			end else begin
				n.hex_value = {s.hex_value[3:0], d[3:0]};
			end
			n.hex_count = s.hex_count + 2'd1;
		end
		if (in_window) begin
			n.char_count = s.char_count + CNT_W'(1);
		end
		return n;
	endfunction

	always_comb begin
		st_d = st_q;
		st_tmp = st_q;
		res = '0;
		len_full = st_q.star_seen ? st_q.star_pos : st_q.char_count;
		len_ext = 11'(len_full);
		res.sentence_type = st_q.type_code;
		res.computed_sum = st_q.xor_acc;
		res.line_length = (len_ext > 11'd127) ? 7'd127 : len_ext[6:0];
		if (!st_q.star_seen) begin
			res.status = ST_NO_STAR;
		end else if (st_q.hex_bad || st_q.hex_count < 2'd2) begin
			res.status = ST_BAD_HEX;
		end else begin
			res.received_sum = st_q.hex_value;
			res.status = (st_q.hex_value == st_q.xor_acc) ? ST_OK : ST_MISMATCH;
		end
		if (data_byte == CH_DOLLAR) begin
			st_d = '0;
			st_d.active = 1'b1;
			st_d.type_code = TYPE_NONE;
		end else if (st_q.active) begin
			if (st_q.pending_cr && data_byte == CH_LF) begin
				st_d.active = 1'b0;
				st_d.pending_cr = 1'b0;
				res.valid = (st_q.type_code < 3'(NUM_TYPES)) &&
					wanted_types[st_q.type_code];
			end else begin
				if (st_q.pending_cr) begin
					st_tmp = take_char(st_q, CH_CR);
					st_tmp.pending_cr = 1'b0;
				end
				if (data_byte == CH_CR) begin
					st_d = st_tmp;
					st_d.pending_cr = 1'b1;
				end else begin
					st_d = take_char(st_tmp, data_byte);
				end
			end
		end
		if (!res.valid) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_IDLE;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	a_res_type: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.sentence_type < 3'(NUM_TYPES)) && wanted_types[res.sentence_type])
		else $error("result for a type that is unknown or not wanted");

	a_rsum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == ST_BAD_HEX || res.status == ST_NO_STAR)
		|-> res.received_sum == 8'd0)
		else $error("received checksum not zero on a failed decode");

	a_line_closed: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid |=> !st_q.active)
		else $error("line still open after its result");

	a_hex_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.hex_count != 2'd3)
		else $error("more than two checksum digits taken");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for nmea_sentence_checker: streams NMEA sentences one word at a time,
// predicts every result word with a behavioral model of the line checker and
// compares it field by field. Depends on nsc_pkg and the checker RTL.
module tb;
	import nsc_pkg::*;

	localparam int LINE_WINDOW = MAX_LINE_LEN - 1;
	localparam logic [2:0] REG_WANTED = 3'd0;
	localparam logic [2:0] REG_SPARE = 3'd4;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_BYTES = 400;

	typedef enum int {
		TAIL_GOOD, TAIL_WRONG, TAIL_BADHEX, TAIL_ONE_DIGIT, TAIL_NO_DIGIT, TAIL_NO_STAR,
		TAIL_TRAILER
	} tail_t;

	typedef struct {
		logic [2:0] kind;
		logic [1:0] stat;
		logic [7:0] calc_sum;
		logic [7:0] rx_sum;
		logic [6:0] len;
	} sentence_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  sentence_type;
	logic [1:0]  status;
	logic [7:0]  computed_sum;
	logic [7:0]  received_sum;
	logic [6:0]  line_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	logic [5:0] wanted_mask = 6'h3F;
	logic       line_open = 1'b0;
	logic       cr_held = 1'b0;
	logic       star_hit = 1'b0;
	logic       digits_bad = 1'b0;
	logic [7:0] run_xor = 8'h00;
	logic [7:0] digits_val = 8'h00;
	logic [7:0] type_c0 = 8'h00;
	logic [7:0] type_c1 = 8'h00;
	logic [2:0] kind_code = TYPE_NONE;
	int         char_pos = 0;
	int         star_at = 0;
	int         digit_cnt = 0;

	sentence_report_t reports_due[$];
	logic [7:0]       tx_buf[$];
	int               error_count = 0;
	int               useful_bytes = 0;
	int               idle_cycles = 0;
	int unsigned      ready_hold = 0;
	bit               calm = 1'b0;

	nmea_sentence_checker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sentence_type(sentence_type),
		.status(status),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.line_length(line_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int hex_value_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
	endfunction

	task automatic open_line();
		line_open = 1'b1;
		cr_held = 1'b0;
		run_xor = 8'h00;
		char_pos = 0;
		kind_code = TYPE_NONE;
		type_c0 = 8'h00;
		type_c1 = 8'h00;
		digits_val = 8'h00;
		digits_bad = 1'b0;
		star_hit = 1'b0;
		digit_cnt = 0;
		star_at = 0;
	endtask

	task automatic absorb_char(input logic [7:0] c);
		int  d;
		bit  in_window;
		in_window = char_pos < LINE_WINDOW;
		if (!star_hit) begin
			if (in_window) begin
				if (c == CH_STAR) begin
					star_hit = 1'b1;
					star_at = char_pos;
				end else begin
					run_xor ^= c;
					if (char_pos == 2) begin
						type_c0 = c;
					end else if (char_pos == 3) begin
						type_c1 = c;
					end else if (char_pos == 4) begin
						for (int i = 0; i < NUM_TYPES; i++) begin
							if (TYPE_TAB[i] == {type_c0, type_c1, c}) kind_code = 3'(i);
						end
					end
				end
			end
		end else if (digit_cnt < 2) begin
			d = in_window ? hex_value_of(c) : -1;
			if (d < 0) digits_bad = 1'b1;
			else digits_val = {digits_val[3:0], 4'(d)};
			digit_cnt++;
		end
		if (char_pos < LINE_WINDOW) char_pos++;
	endtask

	task automatic predict_byte(input logic [7:0] c);
		sentence_report_t r;
		int l;
		if (c == CH_DOLLAR) begin
			open_line();
			useful_bytes++;
			return;
		end
		if (!line_open) return;
		useful_bytes++;
		if (cr_held) begin
			cr_held = 1'b0;
			if (c != CH_LF) begin
				absorb_char(CH_CR);
			end else begin
				line_open = 1'b0;
				if (kind_code < NUM_TYPES && wanted_mask[kind_code]) begin
					r.kind = kind_code;
					r.calc_sum = run_xor;
					if (!star_hit) begin
						r.stat = ST_NO_STAR;
						r.rx_sum = 8'h00;
						l = char_pos;
					end else if (digits_bad || digit_cnt < 2) begin
						r.stat = ST_BAD_HEX;
						r.rx_sum = 8'h00;
						l = star_at;
					end else begin
						r.rx_sum = digits_val;
						r.stat = (digits_val == run_xor) ? ST_OK : ST_MISMATCH;
						l = star_at;
					end
					if (l > 127) l = 127;
					r.len = 7'(l);
					reports_due.push_back(r);
				end
				return;
			end
		end
		if (c == CH_CR) cr_held = 1'b1;
		else absorb_char(c);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
	endtask

	task automatic flush_tx();
		foreach (tx_buf[i]) send_byte(tx_buf[i]);
		tx_buf.delete();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [5:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {26'($urandom()), mask};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_WANTED) wanted_mask = mask;
		@(posedge clk);
	endtask

	function automatic logic [7:0] fill_char();
		logic [7:0] c;
		if ($urandom_range(99) < 90) begin
			do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CH_DOLLAR || c == CH_STAR);
		end else begin
			do c = 8'($urandom_range(255));
			while (c == CH_DOLLAR || c == CH_STAR || c == CH_CR || c == CH_LF);
		end
		return c;
	endfunction

	function automatic logic [7:0] bad_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (hex_value_of(c) >= 0 || c == CH_DOLLAR || c == CH_CR);
		return c;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) tx_buf.push_back(s[i]);
	endtask

	task automatic add_fill(input int n);
		repeat (n) tx_buf.push_back(fill_char());
	endtask

	task automatic add_tail(input tail_t mode);
		logic [7:0] sum;
		logic [7:0] bad;
		sum = 8'h00;
		for (int i = 1; i < tx_buf.size(); i++) sum ^= tx_buf[i];
		if (mode != TAIL_NO_STAR) tx_buf.push_back(CH_STAR);
		case (mode)
			TAIL_GOOD, TAIL_TRAILER: begin
				tx_buf.push_back(hex_char(sum[7:4]));
				tx_buf.push_back(hex_char(sum[3:0]));
				if (mode == TAIL_TRAILER) add_fill($urandom_range(1, 6));
			end
			TAIL_WRONG: begin
				sum ^= 8'($urandom_range(1, 255));
				tx_buf.push_back(hex_char(sum[7:4]));
				tx_buf.push_back(hex_char(sum[3:0]));
			end
			TAIL_BADHEX: begin
				bad = bad_hex_char();
				if ($urandom_range(1)) begin
					tx_buf.push_back(bad);
					tx_buf.push_back(hex_char(sum[3:0]));
				end else begin
					tx_buf.push_back(hex_char(sum[7:4]));
					tx_buf.push_back(bad);
				end
			end
			TAIL_ONE_DIGIT: tx_buf.push_back(hex_char(sum[7:4]));
			default: ;
		endcase
		tx_buf.push_back(CH_CR);
		tx_buf.push_back(CH_LF);
	endtask

	task automatic add_sentence(input int kind_idx, input int nfill, input tail_t mode,
		input bit odd_talker);
		tx_buf.push_back(CH_DOLLAR);
		if (odd_talker) begin
			repeat (2) tx_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
		end else begin
			add_text("GP");
		end
		if (kind_idx >= 0 && kind_idx < NUM_TYPES) begin
			tx_buf.push_back(TYPE_TAB[kind_idx][23:16]);
			tx_buf.push_back(TYPE_TAB[kind_idx][15:8]);
			tx_buf.push_back(TYPE_TAB[kind_idx][7:0]);
		end else begin
			repeat (3) tx_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
		end
		add_fill(nfill);
		add_tail(mode);
		flush_tx();
	endtask

	function automatic tail_t pick_tail();
		int r;
		r = $urandom_range(99);
		if (r < 70) return TAIL_GOOD;
		if (r < 78) return TAIL_WRONG;
		if (r < 84) return TAIL_BADHEX;
		if (r < 87) return TAIL_ONE_DIGIT;
		if (r < 90) return TAIL_NO_DIGIT;
		if (r < 95) return TAIL_NO_STAR;
		return TAIL_TRAILER;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		sentence_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reports_due.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word, expected none got type %0d status %0d",
					$time, sentence_type, status);
			end else begin
				want = reports_due.pop_front();
				check_field("sentence_type", 8'(want.kind), 8'(sentence_type));
				check_field("status", 8'(want.stat), 8'(status));
				check_field("computed_sum", want.calc_sum, computed_sum);
				check_field("received_sum", want.rx_sum, received_sum);
				check_field("line_length", 8'(want.len), 8'(line_length));
			end
		end
	end

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
		end else if (calm || $urandom_range(2) != 0) begin
			out_ready <= 1'b1;
			ready_hold = $urandom_range(6);
		end else begin
			out_ready <= 1'b0;
			ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_each_type();
		tx_buf.push_back(8'h00);
		tx_buf.push_back(8'hFF);
		tx_buf.push_back(CH_LF);
		tx_buf.push_back(CH_CR);
		tx_buf.push_back(CH_STAR);
		tx_buf.push_back(8'h55);
		tx_buf.push_back(8'hAA);
		flush_tx();
		for (int i = 0; i < NUM_TYPES; i++) add_sentence(i, $urandom_range(0, 12), TAIL_GOOD, 0);
	endtask

	task automatic test_status_codes();
		add_sentence(2, 10, TAIL_WRONG, 0);
		add_sentence(0, 8, TAIL_BADHEX, 0);
		add_sentence(1, 6, TAIL_ONE_DIGIT, 0);
		add_sentence(3, 4, TAIL_NO_DIGIT, 0);
		add_sentence(4, 9, TAIL_NO_STAR, 0);
		add_sentence(5, 7, TAIL_TRAILER, 0);
		add_text("$GPRMC,1*4a\r\n");
		add_text("$GPGGA,2*Z1\r\n");
		flush_tx();
	endtask

	task automatic test_line_quirks();
		add_text("$GPGGA,12");
		flush_tx();
		add_sentence(1, 5, TAIL_GOOD, 0);
		add_text("$GPGLL,1\r2,3");
		add_tail(TAIL_GOOD);
		add_text("$GPGSA,\n5");
		add_tail(TAIL_GOOD);
		add_text("$GPVTG\r\r\n");
		add_text("$GPXYZ,1");
		add_tail(TAIL_GOOD);
		add_text("$GP\r\n");
		add_text("$GPG*A,1");
		add_tail(TAIL_GOOD);
		add_text("$GPGGA,");
		tx_buf.push_back(8'h00);
		tx_buf.push_back(8'h80);
		add_tail(TAIL_GOOD);
		flush_tx();
	endtask

	task automatic test_window_edges();
		add_sentence(0, LINE_WINDOW - 8, TAIL_GOOD, 0);
		add_sentence(1, LINE_WINDOW - 7, TAIL_GOOD, 0);
		add_sentence(2, LINE_WINDOW - 6, TAIL_GOOD, 0);
		add_sentence(3, LINE_WINDOW - 5, TAIL_GOOD, 0);
		add_sentence(4, 200, TAIL_NO_STAR, 0);
	endtask

	task automatic test_type_mask();
		wait_idle();
		cfg_write(REG_WANTED, 6'h00);
		for (int i = 0; i < NUM_TYPES; i++) add_sentence(i, 3, TAIL_GOOD, 0);
		wait_idle();
		cfg_write(REG_WANTED, 6'h3F);
		cfg_write(REG_SPARE, 6'h00);
		add_sentence(5, 3, TAIL_GOOD, 0);
		for (int b = 0; b < NUM_TYPES; b++) begin
			wait_idle();
			cfg_write(REG_WANTED, 6'(1 << b));
			add_sentence(b, 2, TAIL_GOOD, 0);
			add_sentence((b + 1) % NUM_TYPES, 2, TAIL_WRONG, 0);
		end
		wait_idle();
		cfg_write(REG_WANTED, 6'h3F);
	endtask

	task automatic test_random();
		int bytes_goal;
		int n_lines;
		int r;
		int nfill;
		bytes_goal = useful_bytes + RANDOM_BYTES;
		n_lines = 0;
		while (useful_bytes < bytes_goal) begin
			if (n_lines % 16 == 0) begin
				wait_idle();
				calm = ($urandom_range(4) == 0);
				r = $urandom_range(5);
				cfg_write(REG_WANTED, (r == 0) ? 6'h00 : (r == 1) ? 6'h3F : 6'($urandom()));
			end
			n_lines++;
			r = $urandom_range(99);
			nfill = ($urandom_range(99) < 3) ? $urandom_range(110, 160) : $urandom_range(0, 30);
			if (r < 80) begin
				add_sentence(($urandom_range(9) < 9) ? $urandom_range(5) : NUM_TYPES, nfill,
					pick_tail(), 1);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8)) tx_buf.push_back(8'($urandom_range(255)));
				flush_tx();
			end else begin
				tx_buf.push_back(CH_DOLLAR);
				add_text("GN");
				tx_buf.push_back(TYPE_TAB[$urandom_range(5)][23:16]);
				add_fill($urandom_range(0, 12));
				if ($urandom_range(1)) begin
					tx_buf.push_back(CH_CR);
					tx_buf.push_back(fill_char());
				end
				flush_tx();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_type();
		test_status_codes();
		test_line_quirks();
		test_window_edges();
		test_type_mask();
		test_random();
		wait_idle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
